/* rtl/eyer_pkg.sv */
package eyer_pkg;

	localparam int NUM_LANES = 8;

	// register indexes of the configuration port
	localparam logic REG_ROTATE_CCW    = 1'b0;
	localparam logic REG_COLUMN_OFFSET = 1'b1;

	localparam logic       ROTATE_CCW_RST    = 1'b1;
	localparam logic [2:0] COLUMN_OFFSET_RST = 3'd2;
	localparam logic [7:0] BYTE_BLANK        = 8'hFF;

	// ellipse centres (portrait coordinates)
	localparam logic signed [8:0] CX_EYE      = 9'sd32;
	localparam logic signed [8:0] CY_OPEN     = 9'sd64;
	localparam logic signed [8:0] CY_BLK_UP   = 9'sd104;
	localparam logic signed [8:0] CY_BLK_DOWN = 9'sd88;
	localparam logic signed [8:0] CY_WHT_UP   = 9'sd82;
	localparam logic signed [8:0] CY_WHT_DOWN = 9'sd110;

	// squared radii and right-hand sides of the ellipse test
	localparam logic [10:0] OPEN_RX2  = 11'd256;
	localparam logic [10:0] OPEN_RY2  = 11'd1600;
	localparam logic [25:0] OPEN_LIM  = 26'd409600;
	localparam logic [10:0] BLK_RX2   = 11'd484;
	localparam logic [10:0] BLK_RY2   = 11'd256;
	localparam logic [25:0] BLK_LIM   = 26'd123904;
	localparam logic [10:0] WHT_RX2   = 11'd676;
	localparam logic [10:0] WHT_RY2   = 11'd324;
	localparam logic [25:0] WHT_LIM   = 26'd219024;

	typedef struct packed {
		logic [6:0]        px;
		logic [2:0]        page;
		logic              rot_ccw;
		logic              eye_open;
		logic signed [3:0] look_x;
		logic signed [4:0] look_y;
		logic              smile;
	} eyer_s1_t;

	typedef struct packed {
		logic load_s2;
		logic load_s3;
	} eyer_adv_t;

	typedef struct packed {
		logic valid_s3;
		logic win_s3;
		logic rdy_out;
	} eyer_mctl_t;

endpackage

/* rtl/eyer_lane.sv */
module eyer_lane (
	input  logic               clk,
	input  eyer_pkg::eyer_adv_t adv,
	input  eyer_pkg::eyer_s1_t  item,
	input  logic [2:0]         row,
	output logic               lit
);
	import eyer_pkg::*;

	logic [5:0]        py;
	logic [5:0]        x;
	logic [6:0]        y;
	logic signed [8:0] cxa, cya, cyb;
	logic signed [8:0] dxa, dya, dxb, dyb;
	logic signed [17:0] pxa, pya, pxb, pyb;
	logic [13:0]       sqxa_s2, sqya_s2, sqxb_s2, sqyb_s2;
	logic              open_s2;
	logic [10:0]       rx2a, ry2a;
	logic [25:0]       lima, suma, sumb;
	logic              ina, inb;
	logic              lit_s3;

	always_comb begin
		py = {item.page, row};
		x  = item.rot_ccw ? py : ~py;
		y  = item.rot_ccw ? ~item.px : item.px;
		if (item.eye_open) begin
			cxa = CX_EYE + {{5{item.look_x[3]}}, item.look_x};
			cya = CY_OPEN + {{4{item.look_y[4]}}, item.look_y};
		end else begin
			cxa = CX_EYE;
			cya = item.smile ? CY_BLK_UP : CY_BLK_DOWN;
		end
		cyb = item.smile ? CY_WHT_UP : CY_WHT_DOWN;
		dxa = $signed({3'b000, x}) - cxa;
		dya = $signed({2'b00, y}) - cya;
		dxb = $signed({3'b000, x}) - CX_EYE;
		dyb = $signed({2'b00, y}) - cyb;
		pxa = dxa * dxa;
		pya = dya * dya;
		pxb = dxb * dxb;
		pyb = dyb * dyb;
	end

	always_ff @(posedge clk) begin
		if (adv.load_s2) begin
			sqxa_s2 <= pxa[13:0];
			sqya_s2 <= pya[13:0];
			sqxb_s2 <= pxb[13:0];
			sqyb_s2 <= pyb[13:0];
			open_s2 <= item.eye_open;
		end
	end

	always_comb begin
		rx2a = open_s2 ? OPEN_RX2 : BLK_RX2;
		ry2a = open_s2 ? OPEN_RY2 : BLK_RY2;
		lima = open_s2 ? OPEN_LIM : BLK_LIM;
		suma = 26'(sqxa_s2 * ry2a) + 26'(sqya_s2 * rx2a);
		sumb = 26'(sqxb_s2 * WHT_RY2) + 26'(sqyb_s2 * WHT_RX2);
		ina  = suma <= lima;
		inb  = sumb <= WHT_LIM;
	end

	always_ff @(posedge clk) begin
		if (adv.load_s3)
			lit_s3 <= open_s2 ? !ina : (inb || !ina);
	end

	assign lit = lit_s3;

endmodule

/* rtl/eyer_merge.sv */
module eyer_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  eyer_pkg::eyer_mctl_t          ctl,
	input  logic [eyer_pkg::NUM_LANES-1:0] lit,
	output logic                          out_valid,
	output logic [7:0]                    out_byte
);
	import eyer_pkg::*;

	logic       valid_q;
	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (ctl.rdy_out)
			valid_q <= ctl.valid_s3;
	end

	always_ff @(posedge clk) begin
		if (ctl.rdy_out && ctl.valid_s3)
			byte_q <= ctl.win_s3 ? lit : BYTE_BLANK;
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;

endmodule

/* rtl/eye_ellipse_page_raster.sv */
// Eye raster for a page-organised 132-column monochrome panel: each input beat
// asks for one column byte of one page and returns eight vertical pixels (bit n
// is row page*8+n, 1 lit) of a cartoon eye, open or closed, on a portrait 64x128
// frame rotated onto the panel. Eight row lanes evaluate the ellipse tests side
// by side and a merge stage packs their bits, so one beat is taken every cycle;
// unless the output stalls; a result passes input stage, squares, ellipse compare
// and output register, and stalls only back-pressure the stages behind a full
// output. Columns outside the 128-column window read 0xFF. The user must write
// registers on the cfg channel while no request is in flight; nothing enforces it.
module eye_ellipse_page_raster (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// column[7:0], page[10:8], eye_open[11], look_x[15:12], look_y[20:16], smile[21]
	input  logic [23:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pixel_byte[7:0]
	output logic [7:0]  m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [2:0]  cfg_data
);
	import eyer_pkg::*;

	logic           rot_ccw_q;
	logic [2:0]     col_off_q;
	logic           v_s1, v_s2, v_s3;
	logic           win_s1, win_s2, win_s3;
	logic           rdy1, rdy2, rdy3, rdy4;
	logic [7:0]     column;
	logic [8:0]     col_end;
	logic           in_win;
	eyer_s1_t       item_s1;
	eyer_adv_t      adv;
	eyer_mctl_t     mctl;
	logic [NUM_LANES-1:0] lit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_ccw_q <= ROTATE_CCW_RST;
			col_off_q <= COLUMN_OFFSET_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROTATE_CCW:    rot_ccw_q <= cfg_data[0];
				REG_COLUMN_OFFSET: col_off_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rdy4 = !m_axis_tvalid || m_axis_tready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	assign column  = s_axis_tdata[7:0];
	assign col_end = {6'd0, col_off_q} + 9'd128;
	assign in_win  = (column >= {5'd0, col_off_q}) && ({1'b0, column} < col_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1)
				v_s1 <= s_axis_tvalid;
			if (rdy2)
				v_s2 <= v_s1;
			if (rdy3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_axis_tvalid) begin
			item_s1.px       <= 7'(column - {5'd0, col_off_q});
			item_s1.page     <= s_axis_tdata[10:8];
			item_s1.rot_ccw  <= rot_ccw_q;
			item_s1.eye_open <= s_axis_tdata[11];
			item_s1.look_x   <= s_axis_tdata[15:12];
			item_s1.look_y   <= s_axis_tdata[20:16];
			item_s1.smile    <= s_axis_tdata[21];
			win_s1           <= in_win;
		end
		if (adv.load_s2)
			win_s2 <= win_s1;
		if (adv.load_s3)
			win_s3 <= win_s2;
	end

	assign adv.load_s2 = rdy2 && v_s1;
	assign adv.load_s3 = rdy3 && v_s2;

	for (genvar n = 0; n < NUM_LANES; n++) begin : g_lane
		eyer_lane u_lane (
			.clk  (clk),
			.adv  (adv),
			.item (item_s1),
			.row  (3'(n)),
			.lit  (lit[n])
		);
	end

	assign mctl.valid_s3 = v_s3;
	assign mctl.win_s3   = win_s3;
	assign mctl.rdy_out  = rdy4;

	eyer_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mctl),
		.lit       (lit),
		.out_valid (m_axis_tvalid),
		.out_byte  (m_axis_tdata)
	);

`ifndef ASSERT_OFF
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	a_s3_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready && v_s3) |=> v_s3)
		else $error("stage 3 beat lost during stall");

	a_bubble_collapse: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !v_s2 && !v_s3 && !m_axis_tvalid) |=> v_s2)
		else $error("stage 1 beat did not advance");
`endif

endmodule
